// ===== rtl/bitmap_row_run_encoder_unit_defines.svh =====
// Assertion macros shared by the run encoder modules.
`ifndef BITMAP_ROW_RUN_ENCODER_UNIT_DEFINES_SVH
`define BITMAP_ROW_RUN_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BRRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define BRRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BRRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BRRE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/brre_pkg.sv =====
// Types and constants shared by the bitmap row run encoder.
package brre_pkg;

    localparam int DefMaxWidth = 4096;
    localparam int LaneCount   = 8;
    localparam int SlotCount   = LaneCount + 1;
    localparam int NarrowLimit = 256;
    localparam int TdataW      = 40;
    localparam int TuserW      = 2;
    localparam int CfgDataW    = 13;

    localparam logic [12:0] RowWidthReset = 13'd8;

    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_TRAILER = 1'b1;

    localparam logic CFG_ROW_WIDTH = 1'b0;
    localparam logic CFG_NARROW    = 1'b1;

    typedef struct packed {
        logic        close;
        logic        opened;
        logic        start_ge;
        logic [11:0] start;
        logic [12:0] len;
        logic        big;
    } t_lane_rec;

    typedef struct packed {
        logic        valid;
        logic        big;
        logic [11:0] count;
    } t_trailer;

    typedef struct packed {
        logic        kind;
        logic        big;
        logic [11:0] start;
        logic [12:0] len;
        logic [11:0] count;
        logic        last;
    } t_out_rec;

endpackage

// ===== rtl/brre_lane.sv =====
// One pixel lane: finds whether a run closes at this position and its record.
module brre_lane #(
    parameter int LANE = 0,
    parameter int POS_W = 13
) (
    input  logic [brre_pkg::LaneCount:0] i_set,
    input  logic [brre_pkg::LaneCount:0] i_valid,
    input  logic                         i_in_run,
    input  logic                         i_row_end,
    input  logic [POS_W-1:0]             i_pos,
    input  logic [11:0]                  i_start,
    input  logic                         i_start_ge,
    input  logic [12:0]                  i_len,
    input  logic                         i_narrow,
    output brre_pkg::t_lane_rec          o_rec
);

    logic [brre_pkg::LaneCount:0] prev;
    logic [brre_pkg::LaneCount:0] opens;
    logic                         found;
    logic [3:0]                   last_open;
    logic [POS_W:0]               sum;
    logic [12:0]                  len;
    logic                         start_ge;

    always_comb begin
        prev[0] = i_in_run;
        for (int j = 1; j <= brre_pkg::LaneCount; j++) begin
            prev[j] = i_set[j-1];
        end
        opens = i_set & ~prev;
        found = 1'b0;
        last_open = '0;
        for (int j = 0; j < LANE; j++) begin
            if (opens[j]) begin
                found = 1'b1;
                last_open = 4'(j);
            end
        end
        sum = (POS_W+1)'(i_pos) + (POS_W+1)'(last_open);
        if (found) begin
            len = 13'(LANE) - 13'(last_open);
            start_ge = (32'(sum) >= brre_pkg::NarrowLimit);
            o_rec.start = 12'(sum);
        end else begin
            len = i_len + 13'(LANE);
            start_ge = i_start_ge;
            o_rec.start = i_start;
        end
        o_rec.close = prev[LANE] & ~i_set[LANE] & (i_valid[LANE] | i_row_end);
        o_rec.opened = opens[LANE];
        o_rec.start_ge = start_ge;
        o_rec.len = len;
        o_rec.big = i_narrow & (start_ge | (32'(len) >= brre_pkg::NarrowLimit));
    end

endmodule

// ===== rtl/brre_merge.sv =====
// Result slot and serialiser that merges the lane records into the output stream.
`include "bitmap_row_run_encoder_unit_defines.svh"
module brre_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  brre_pkg::t_lane_rec i_recs [brre_pkg::SlotCount],
    input  brre_pkg::t_trailer  i_trl,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output brre_pkg::t_out_rec  o_rec
);

    logic [brre_pkg::SlotCount-1:0] r_mask, n_mask;
    brre_pkg::t_lane_rec            r_recs [brre_pkg::SlotCount];
    brre_pkg::t_trailer             r_trl, n_trl;
    logic                           r_out_valid, n_out_valid;
    brre_pkg::t_out_rec             r_out, n_out;

    logic [brre_pkg::SlotCount-1:0] pick;
    logic [brre_pkg::SlotCount-1:0] mask_rest;
    logic [brre_pkg::SlotCount-1:0] load_mask;
    brre_pkg::t_lane_rec            head;
    logic                           slot_has;
    logic                           advance;
    logic                           pop_last;

    always_comb begin
        slot_has = (|r_mask) | r_trl.valid;
        pick = r_mask & (~r_mask + 1'b1);
        mask_rest = r_mask & ~pick;
        head = '0;
        for (int i = 0; i < brre_pkg::SlotCount; i++) begin
            if (pick[i]) begin
                head = head | r_recs[i];
            end
        end
        for (int i = 0; i < brre_pkg::SlotCount; i++) begin
            load_mask[i] = i_recs[i].close;
        end
        advance = slot_has & (~r_out_valid | i_ready);
        pop_last = (|r_mask) ? ((mask_rest == '0) & ~r_trl.valid) : 1'b1;
        o_free = ~slot_has | (advance & pop_last);

        n_mask = r_mask;
        n_trl = r_trl;
        n_out = r_out;
        n_out_valid = r_out_valid & ~i_ready;
        if (advance) begin
            n_out_valid = 1'b1;
            if (|r_mask) begin
                n_out.kind = brre_pkg::KIND_RUN;
                n_out.big = head.big;
                n_out.start = head.start;
                n_out.len = head.len;
                n_out.count = '0;
                n_mask = mask_rest;
            end else begin
                n_out.kind = brre_pkg::KIND_TRAILER;
                n_out.big = r_trl.big;
                n_out.start = '0;
                n_out.len = '0;
                n_out.count = r_trl.count;
                n_trl.valid = 1'b0;
            end
            n_out.last = pop_last;
        end
        if (i_load) begin
            n_mask = load_mask;
            n_trl = i_trl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_trl.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            r_trl.valid <= n_trl.valid;
            r_out_valid <= n_out_valid;
        end
        r_trl.big <= n_trl.big;
        r_trl.count <= n_trl.count;
        r_out <= n_out;
        if (i_load) begin
            r_recs <= i_recs;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rec = r_out;

    `BRRE_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, i_load, o_free)
    `BRRE_ASSERT_IMPLY(a_trailer_last, i_clk, i_rst_n, r_out_valid && r_out.kind == brre_pkg::KIND_TRAILER, r_out.last)
    `BRRE_ASSERT_NEXT(a_trailer_held, i_clk, i_rst_n, i_load && i_trl.valid, r_trl.valid || r_out_valid)

endmodule

// ===== rtl/bitmap_row_run_encoder_unit.sv =====
// Top level of the bitmap row run encoder: row state, pixel lanes and result merge.
// A byte's results are registered in the result slot, then move one by one into the output register.
// A byte giving k results holds the result slot until its last result moves out, one result per cycle while
// the output channel is ready; eight lanes plus a row-end lane evaluate every pixel of a byte at once.
// Reset is synchronous and active low: row state and pending results are cleared, row_width
// returns to 8 and narrow_format to 0.
`include "bitmap_row_run_encoder_unit_defines.svh"
module bitmap_row_run_encoder_unit #(
    parameter int MAX_WIDTH = brre_pkg::DefMaxWidth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [brre_pkg::TdataW-1:0]   m_axis_tdata,  // run_start, run_length, run_count, pad
    output logic [brre_pkg::TuserW-1:0]   m_axis_tuser,  // record_kind, too_big
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_addr,
    input  logic [brre_pkg::CfgDataW-1:0] i_cfg_data
);

    localparam int PosW = $clog2(MAX_WIDTH + 1);

    logic [12:0]     r_row_width;
    logic            r_narrow;
    logic [PosW-1:0] r_pos, n_pos;
    logic            r_in_run, n_in_run;
    logic [11:0]     r_start, n_start;
    logic            r_start_ge, n_start_ge;
    logic [12:0]     r_len, n_len;
    logic [11:0]     r_count, n_count;

    logic [31:0]                  width32;
    logic [PosW-1:0]              width_eff;
    logic [PosW-1:0]              avail;
    logic                         row_end;
    logic [brre_pkg::LaneCount:0] valid9;
    logic [brre_pkg::LaneCount:0] set9;
    logic                         accept;
    logic [11:0]                  count_next;
    brre_pkg::t_lane_rec          lane_recs [brre_pkg::SlotCount];
    brre_pkg::t_trailer           trailer;
    brre_pkg::t_out_rec           out_rec;

    assign accept = s_axis_tvalid & s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        width32 = 32'(r_row_width);
        if (width32 == '0) begin
            width32 = 32'd1;
        end
        if (width32 > 32'(MAX_WIDTH)) begin
            width32 = 32'(MAX_WIDTH);
        end
        width_eff = PosW'(width32);
        avail = (r_pos < width_eff) ? (width_eff - r_pos) : '0;
        row_end = (32'(avail) <= brre_pkg::LaneCount);
        valid9[brre_pkg::LaneCount] = 1'b0;
        for (int b = 0; b < brre_pkg::LaneCount; b++) begin
            valid9[b] = (32'(avail) > b);
        end
        set9 = {1'b0, s_axis_tdata} & valid9;
    end

    for (genvar g = 0; g < brre_pkg::SlotCount; g++) begin : g_lane
        brre_lane #(
            .LANE (g),
            .POS_W(PosW)
        ) u_lane (
            .i_set     (set9),
            .i_valid   (valid9),
            .i_in_run  (r_in_run),
            .i_row_end (row_end),
            .i_pos     (r_pos),
            .i_start   (r_start),
            .i_start_ge(r_start_ge),
            .i_len     (r_len),
            .i_narrow  (r_narrow),
            .o_rec     (lane_recs[g])
        );
    end

    always_comb begin
        count_next = r_count;
        for (int i = 0; i < brre_pkg::LaneCount; i++) begin
            count_next = count_next + 12'(lane_recs[i].opened);
        end
        trailer.valid = row_end;
        trailer.count = count_next;
        trailer.big = r_narrow & (32'(count_next) >= brre_pkg::NarrowLimit);

        if (row_end) begin
            n_pos = '0;
            n_in_run = 1'b0;
            n_start = '0;
            n_start_ge = 1'b0;
            n_len = '0;
            n_count = '0;
        end else begin
            n_pos = r_pos + PosW'(brre_pkg::LaneCount);
            n_in_run = set9[brre_pkg::LaneCount-1];
            n_start = lane_recs[brre_pkg::LaneCount].start;
            n_start_ge = lane_recs[brre_pkg::LaneCount].start_ge;
            n_len = lane_recs[brre_pkg::LaneCount].len;
            n_count = count_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= brre_pkg::RowWidthReset;
            r_narrow <= 1'b0;
            r_pos <= '0;
            r_in_run <= 1'b0;
            r_start <= '0;
            r_start_ge <= 1'b0;
            r_len <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    brre_pkg::CFG_ROW_WIDTH: begin
                        r_row_width <= i_cfg_data;
                    end
                    brre_pkg::CFG_NARROW: begin
                        r_narrow <= i_cfg_data[0];
                    end
                    default: begin
                        r_narrow <= r_narrow;
                    end
                endcase
            end
            if (accept) begin
                r_pos <= n_pos;
                r_in_run <= n_in_run;
                r_start <= n_start;
                r_start_ge <= n_start_ge;
                r_len <= n_len;
                r_count <= n_count;
            end
        end
    end

    brre_merge u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (accept),
        .i_recs (lane_recs),
        .i_trl  (trailer),
        .o_free (s_axis_tready),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_rec  (out_rec)
    );

    assign m_axis_tdata = {3'b000, out_rec.count, out_rec.len, out_rec.start};
    assign m_axis_tuser = {out_rec.big, out_rec.kind};
    assign m_axis_tlast = out_rec.last;

    `BRRE_ASSERT_NEXT(a_row_end_clears, i_clk, i_rst_n, accept && row_end, r_pos == '0 && !r_in_run && r_count == '0)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the bitmap row run encoder unit.
module tb;

    localparam int HalfPeriod   = 6;
    localparam int SettleCycles = 8;
    localparam int LimitCycles  = 400000;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = 8'h00;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [brre_pkg::TdataW-1:0]   m_axis_tdata;
    logic [brre_pkg::TuserW-1:0]   m_axis_tuser;
    logic                          m_axis_tlast;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic                          i_cfg_addr    = brre_pkg::CFG_ROW_WIDTH;
    logic [brre_pkg::CfgDataW-1:0] i_cfg_data    = '0;

    logic [7:0]         pixel_queue[$];
    brre_pkg::t_out_rec expected_records[$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    logic               rx_hold        = 1'b0;
    int                 mismatch_count = 0;

    logic [12:0] row_width_cfg = brre_pkg::RowWidthReset;
    logic        narrow_cfg    = 1'b0;
    logic [12:0] pixel_pos     = '0;
    logic        run_open      = 1'b0;
    logic [11:0] run_first     = '0;
    logic [12:0] run_len       = '0;
    logic [11:0] runs_in_row   = '0;

    bitmap_row_run_encoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #HalfPeriod i_clk = ~i_clk;

    function automatic brre_pkg::t_out_rec make_record(logic kind, logic [11:0] start,
                                                       logic [12:0] len, logic [11:0] count);
        brre_pkg::t_out_rec rec;
        rec.kind  = kind;
        rec.start = start;
        rec.len   = len;
        rec.count = count;
        rec.last  = 1'b0;
        if (kind == brre_pkg::KIND_RUN) begin
            rec.big = narrow_cfg && (start >= brre_pkg::NarrowLimit ||
                                     len >= brre_pkg::NarrowLimit);
        end else begin
            rec.big = narrow_cfg && (count >= brre_pkg::NarrowLimit);
        end
        return rec;
    endfunction

    function automatic void encode_byte(logic [7:0] pixels);
        int                 eff_width;
        brre_pkg::t_out_rec batch[$];
        brre_pkg::t_out_rec tail;
        eff_width = row_width_cfg;
        if (eff_width == 0) eff_width = 1;
        if (eff_width > brre_pkg::DefMaxWidth) eff_width = brre_pkg::DefMaxWidth;
        for (int b = 0; b < 8 && pixel_pos < eff_width; b++) begin
            if (pixels[b]) begin
                if (!run_open) begin
                    run_open    = 1'b1;
                    run_first   = pixel_pos[11:0];
                    run_len     = 13'd1;
                    runs_in_row = runs_in_row + 12'd1;
                end else begin
                    run_len = run_len + 13'd1;
                end
            end else if (run_open) begin
                batch.push_back(make_record(brre_pkg::KIND_RUN, run_first, run_len, 12'd0));
                run_open = 1'b0;
            end
            pixel_pos = pixel_pos + 13'd1;
        end
        if (pixel_pos >= eff_width) begin
            if (run_open) begin
                batch.push_back(make_record(brre_pkg::KIND_RUN, run_first, run_len, 12'd0));
            end
            batch.push_back(make_record(brre_pkg::KIND_TRAILER, 12'd0, 13'd0, runs_in_row));
            pixel_pos   = '0;
            run_open    = 1'b0;
            run_first   = '0;
            run_len     = '0;
            runs_in_row = '0;
        end
        if (batch.size() > 0) begin
            tail      = batch.pop_back();
            tail.last = 1'b1;
            batch.push_back(tail);
        end
        foreach (batch[i]) expected_records.push_back(batch[i]);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [7:0] rand_pixels();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'(1 << $urandom_range(7));
            3: return 8'($urandom & $urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_byte(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata  <= pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        brre_pkg::t_out_rec want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_records.size() == 0) begin
                    $error("result beat arrived with no expectation waiting");
                    mismatch_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("record_kind", want.kind, m_axis_tuser[0]);
                    check_field("run_start", want.start, m_axis_tdata[11:0]);
                    check_field("run_length", want.len, m_axis_tdata[24:12]);
                    check_field("run_count", want.count, m_axis_tdata[36:25]);
                    check_field("too_big", want.big, m_axis_tuser[1]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic addr, logic [brre_pkg::CfgDataW-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (addr == brre_pkg::CFG_ROW_WIDTH) begin
            row_width_cfg = value;
        end else begin
            narrow_cfg = value[0];
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || expected_records.size() != 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic push_bytes(logic [7:0] bytes[$]);
        @(negedge i_clk);
        foreach (bytes[i]) pixel_queue.push_back(bytes[i]);
        wait_idle();
    endtask

    task automatic run_phase(int width, int narrow, int send_pct, int recv_pct, int count);
        write_reg(brre_pkg::CFG_ROW_WIDTH, brre_pkg::CfgDataW'(width));
        write_reg(brre_pkg::CFG_NARROW, brre_pkg::CfgDataW'(narrow));
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) pixel_queue.push_back(rand_pixels());
        wait_idle();
    endtask

    initial begin
        logic [7:0] bytes[$];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_bytes({8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h81});
        write_reg(brre_pkg::CFG_ROW_WIDTH, 13'd16);
        push_bytes({8'h80, 8'hAA, 8'hFF, 8'hFF, 8'h01, 8'h00});
        write_reg(brre_pkg::CFG_ROW_WIDTH, 13'd0);
        push_bytes({8'hFE, 8'h01, 8'hFF});
        write_reg(brre_pkg::CFG_ROW_WIDTH, 13'd13);
        push_bytes({8'hFF, 8'hFF, 8'h3C, 8'hE7});

        // An out-of-range width clamps; lowering it mid-row ends the row on the next beat.
        write_reg(brre_pkg::CFG_ROW_WIDTH, 13'd8191);
        write_reg(brre_pkg::CFG_NARROW, 13'd1);
        push_bytes({8'hFF, 8'hF0});
        write_reg(brre_pkg::CFG_ROW_WIDTH, 13'd9);
        push_bytes({8'h00});

        write_reg(brre_pkg::CFG_ROW_WIDTH, 13'd520);
        bytes = {};
        repeat (65) bytes.push_back(8'hFF);
        push_bytes(bytes);

        bytes = {};
        repeat (65) bytes.push_back(8'h55);
        push_bytes(bytes);

        fork
            begin
                @(negedge i_clk);
                rx_hold = 1'b1;
                repeat (400) @(negedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        run_phase($urandom_range(1, 40), 0, 0, 0, 30);
        run_phase($urandom_range(1, 40), 1, 53, 0, 30);
        run_phase($urandom_range(257, 320), 1, 0, 53, 40);
        run_phase($urandom_range(1, 100), 0, 28, 28, 25);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(2 * HalfPeriod * LimitCycles);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/brre_pkg.sv
rtl/brre_lane.sv
rtl/brre_merge.sv
rtl/bitmap_row_run_encoder_unit.sv
tb/tb.sv
